>>> hw/rtl/tcls_pkg.sv
// Shared constants for the two-class LIFO selector.
// Status and kind codes, default sizes. No dependencies.
package tcls_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int ID_BITS_DEF     = 16;
  localparam int ADDR_BITS       = 64;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

endpackage

>>> hw/rtl/two_class_lifo_selector_top.sv
// Two-class LIFO selector: high and low priority stacks of entry identifiers.
// Depends on tcls_pkg (status/kind codes, defaults).

// One item at a time. An add writes its stack in S_ADD, then passes S_TOPRD
// and S_DONE to the output register. A remove walks the high stack and then the
// low stack one entry per cycle through a single compare unit, compacting in
// place. A finished result waits in the output register; the next item may be
// accepted while it waits. Stacks are not cleared at reset; only entries below
// the counts are read.
module two_class_lifo_selector_top #(
  parameter int STACK_DEPTH = tcls_pkg::STACK_DEPTH_DEF,
  parameter int ID_BITS     = tcls_pkg::ID_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wen,
  input  logic [tcls_pkg::ADDR_BITS-1:0] cfg_wdata,  // tracked_address
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [ID_BITS-1:0] entry_id, [ID_BITS+63:ID_BITS] branch_target, zero pad
  input  logic [((ID_BITS+tcls_pkg::ADDR_BITS+7)/8)*8-1:0] in_tdata,
  input  logic                        in_tuser,   // kind
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [1:0] status, [ID_BITS+1:2] selected_id, [ID_BITS+2] selected_high,
  // [ID_BITS+3] all_empty, zero pad
  output logic [((ID_BITS+4+7)/8)*8-1:0] out_tdata
);

  localparam int AW       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW       = $clog2(STACK_DEPTH + 1);
  localparam int OUT_W    = ((ID_BITS + 4 + 7) / 8) * 8;
  localparam int TW       = tcls_pkg::ADDR_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADD   = 3'd1;
  localparam logic [2:0] S_PURGE = 3'd2;
  localparam logic [2:0] S_TOPRD = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  logic [ID_BITS-1:0] hi_mem [STACK_DEPTH];
  logic [ID_BITS-1:0] lo_mem [STACK_DEPTH];
  logic [ID_BITS-1:0] hi_rdata_r, lo_rdata_r;

  logic [2:0]         state_r, state_nxt;
  logic [ID_BITS-1:0] id_r;
  logic [TW-1:0]      tgt_r;
  logic [TW-1:0]      track_r;
  logic [CW-1:0]      hcnt_r, hcnt_nxt, lcnt_r, lcnt_nxt;
  logic [CW-1:0]      idx_r, idx_nxt, kept_r, kept_nxt;
  logic               pend_r, pend_nxt;
  logic               stk_r, stk_nxt;
  logic               hit_r, hit_nxt;
  logic [1:0]         status_r, status_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]   out_data_r, out_data_nxt;

  logic               accept;
  logic               top_rd;
  logic               hi_we, lo_we;
  logic [AW-1:0]      hi_waddr, lo_waddr, hi_raddr, lo_raddr;
  logic [ID_BITS-1:0] wdata;
  logic [CW-1:0]      cur_cnt, hcnt_m1, lcnt_m1;
  logic [ID_BITS-1:0] cmp_data;
  logic               match;
  logic               to_high;
  logic [ID_BITS-1:0] sel_id;
  logic               sel_high, empty;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign cur_cnt  = stk_r ? lcnt_r : hcnt_r;
  assign cmp_data = stk_r ? lo_rdata_r : hi_rdata_r;
  assign match    = (cmp_data == id_r);
  assign to_high  = (tgt_r == track_r);
  assign hcnt_m1  = hcnt_r - 1'b1;
  assign lcnt_m1  = lcnt_r - 1'b1;
  // keep the tops on the read ports while the result waits
  assign top_rd   = (state_r == S_TOPRD) || (state_r == S_DONE);
  assign hi_raddr = top_rd ? hcnt_m1[AW-1:0] : idx_r[AW-1:0];
  assign lo_raddr = top_rd ? lcnt_m1[AW-1:0] : idx_r[AW-1:0];

  always_comb begin
    sel_id   = '0;
    sel_high = 1'b0;
    if (hcnt_r != '0) begin
      sel_id   = hi_rdata_r;
      sel_high = 1'b1;
    end else if (lcnt_r != '0) begin
      sel_id = lo_rdata_r;
    end
    empty = (hcnt_r == '0) && (lcnt_r == '0);
  end

  always_comb begin
    state_nxt     = state_r;
    hcnt_nxt      = hcnt_r;
    lcnt_nxt      = lcnt_r;
    idx_nxt       = idx_r;
    kept_nxt      = kept_r;
    pend_nxt      = pend_r;
    stk_nxt       = stk_r;
    hit_nxt       = hit_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    hi_we         = 1'b0;
    lo_we         = 1'b0;
    hi_waddr      = kept_r[AW-1:0];
    lo_waddr      = kept_r[AW-1:0];
    wdata         = cmp_data;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt    = '0;
          kept_nxt   = '0;
          pend_nxt   = 1'b0;
          stk_nxt    = 1'b0;
          hit_nxt    = 1'b0;
          status_nxt = tcls_pkg::ST_OK;
          state_nxt  = (in_tuser == tcls_pkg::KIND_ADD) ? S_ADD : S_PURGE;
        end
      end
      S_ADD: begin
        wdata = id_r;
        if (to_high) begin
          hi_waddr = hcnt_r[AW-1:0];
          if (hcnt_r >= DEPTH_C) begin
            status_nxt = tcls_pkg::ST_FULL;
          end else begin
            hi_we    = 1'b1;
            hcnt_nxt = hcnt_r + 1'b1;
          end
        end else begin
          lo_waddr = lcnt_r[AW-1:0];
          if (lcnt_r >= DEPTH_C) begin
            status_nxt = tcls_pkg::ST_FULL;
          end else begin
            lo_we    = 1'b1;
            lcnt_nxt = lcnt_r + 1'b1;
          end
        end
        state_nxt = S_TOPRD;
      end
      S_PURGE: begin
        // read of idx in flight; compare/compact the one read last cycle
        if (pend_r) begin
          if (match) begin
            hit_nxt = 1'b1;
          end else begin
            hi_we    = !stk_r;
            lo_we    = stk_r;
            kept_nxt = kept_r + 1'b1;
          end
        end
        if (idx_r < cur_cnt) begin
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (!pend_r && !(idx_r < cur_cnt)) begin
          idx_nxt  = '0;
          kept_nxt = '0;
          if (!stk_r) begin
            hcnt_nxt = kept_r;
            stk_nxt  = 1'b1;
          end else begin
            lcnt_nxt = kept_r;
            if (!hit_r) begin
              status_nxt = tcls_pkg::ST_NOT_FOUND;
            end
            state_nxt = S_TOPRD;
          end
        end
      end
      S_TOPRD: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_W'({empty, sel_high, sel_id, status_r});
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (hi_we) begin
      hi_mem[hi_waddr] <= wdata;
    end
    if (lo_we) begin
      lo_mem[lo_waddr] <= wdata;
    end
    hi_rdata_r <= hi_mem[hi_raddr];
    lo_rdata_r <= lo_mem[lo_raddr];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      id_r   <= in_tdata[ID_BITS-1:0];
      tgt_r  <= in_tdata[ID_BITS+TW-1:ID_BITS];
    end
    out_data_r <= out_data_nxt;
    idx_r      <= idx_nxt;
    kept_r     <= kept_nxt;
    stk_r      <= stk_nxt;
    hit_r      <= hit_nxt;
    status_r   <= status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hcnt_r      <= '0;
      lcnt_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      track_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      hcnt_r      <= hcnt_nxt;
      lcnt_r      <= lcnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wen) begin
        track_r <= cfg_wdata;
      end
    end
  end

endmodule
